>>> design/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, skipped while in reset
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, skipped while in reset
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/smpq_pkg.sv
// shared constants and types of the sorted max priority queue
package smpq_pkg;

  localparam int VALUE_W          = 32;
  localparam int OP_W             = 2;
  localparam int OCC_W            = 5;
  localparam int DEFAULT_CAPACITY = 16;

  // operation codes
  localparam logic [OP_W-1:0] OP_PUSH = 2'd0;
  localparam logic [OP_W-1:0] OP_POP  = 2'd1;
  localparam logic [OP_W-1:0] OP_PEEK = 2'd2;

  // controller to datapath commands
  typedef struct packed {
    logic latch;
    logic execute;
  } cmd_t;

endpackage

>>> design/smpq_req_if.sv
// request channel: one operation per beat
interface smpq_req_if import smpq_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [OP_W-1:0]           op;
  logic signed [VALUE_W-1:0] value;

  modport source (output valid, output op, output value, input ready);
  modport sink (input valid, input op, input value, output ready);
endinterface

>>> design/smpq_rsp_if.sv
// response channel: one result per beat
interface smpq_rsp_if import smpq_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] result_value;
  logic                      was_empty;
  logic                      overflow;
  logic [OCC_W-1:0]          occupancy;

  modport source (output valid, output result_value, output was_empty, output overflow,
                  output occupancy, input ready);
  modport sink (input valid, input result_value, input was_empty, input overflow,
                input occupancy, output ready);
endinterface

>>> design/sorted_max_priority_queue.sv
// sorted max priority queue top level: controller plus cell-row datapath
// the request beat is latched, then the execute state updates the queue and sets the response
// beat valid; execution waits while the previous response beat is still stalled
// a new request is taken only once the previous one has executed; a push compares all cells in parallel
// the response register holds a finished result while the next request is taken
// reset clears the entry count and the response valid; cell contents are not cleared
module sorted_max_priority_queue import smpq_pkg::*; #(
  parameter int CAPACITY = DEFAULT_CAPACITY
) (
  input logic       clk,
  input logic       rst,
  smpq_req_if.sink  req,
  smpq_rsp_if.source rsp
);

  cmd_t cmd;

  // sequencing of each operation
  smpq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .cmd       (cmd)
  );

  // storage and arithmetic
  smpq_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .req_op       (req.op),
    .req_value    (req.value),
    .result_value (rsp.result_value),
    .was_empty    (rsp.was_empty),
    .overflow     (rsp.overflow),
    .occupancy    (rsp.occupancy)
  );

endmodule

>>> design/smpq_ctrl.sv
// controller: accepts a request, runs the update, holds the response beat
module smpq_ctrl import smpq_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  output logic rsp_valid,
  input  logic rsp_ready,
  output cmd_t cmd
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_t;

  state_t state, state_next;
  logic   rsp_full, rsp_full_next;

  // next state and commands
  always_comb begin
    state_next    = state;
    rsp_full_next = rsp_full && !rsp_ready;
    cmd           = '0;
    case (state)
      ST_IDLE: begin
        if (req_valid) begin
          cmd.latch  = 1'b1;
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (!rsp_full || rsp_ready) begin
          cmd.execute   = 1'b1;
          rsp_full_next = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      rsp_full <= 1'b0;
    end else begin
      state    <= state_next;
      rsp_full <= rsp_full_next;
    end
  end

  assign req_ready = (state == ST_IDLE);
  assign rsp_valid = rsp_full;

endmodule

>>> design/smpq_datapath.sv
// datapath: row of sorted cells (largest in cell 0), count and result register
module smpq_datapath import smpq_pkg::*; #(
  parameter int CAPACITY = DEFAULT_CAPACITY
) (
  input  logic                      clk,
  input  logic                      rst,
  input  cmd_t                      cmd,
  input  logic [OP_W-1:0]           req_op,
  input  logic signed [VALUE_W-1:0] req_value,
  output logic signed [VALUE_W-1:0] result_value,
  output logic                      was_empty,
  output logic                      overflow,
  output logic [OCC_W-1:0]          occupancy
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic [OP_W-1:0]           op_q;
  logic signed [VALUE_W-1:0] value_q;
  logic [CNT_W-1:0]          count, count_next;
  logic signed [VALUE_W-1:0] cells [CAPACITY];

  logic signed [VALUE_W-1:0] cell_next [CAPACITY];
  logic [CAPACITY-1:0]       keep;
  logic                      is_push, is_pop, is_peek, full, empty, do_push, do_pop;

  assign is_push = (op_q == OP_PUSH);
  assign is_pop  = (op_q == OP_POP);
  assign is_peek = (op_q == OP_PEEK);
  assign full    = (count == CNT_W'(CAPACITY));
  assign empty   = (count == '0);
  assign do_push = is_push && !full;
  assign do_pop  = is_pop && !empty;

  // request capture
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_q    <= req_op;
      value_q <= req_value;
    end
  end

  // per-cell compare and next value; all cells decide at once
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    assign keep[i] = (count > CNT_W'(i)) && (cells[i] >= value_q);

    if (i == 0) begin : g_head
      always_comb begin
        if (do_push) begin
          cell_next[i] = keep[i] ? cells[i] : value_q;
        end else begin
          cell_next[i] = (CAPACITY > 1) ? cells[(CAPACITY > 1) ? 1 : 0] : cells[i];
        end
      end
    end else begin : g_body
      always_comb begin
        if (do_push) begin
          if (keep[i]) begin
            cell_next[i] = cells[i];
          end else if (keep[i-1]) begin
            cell_next[i] = value_q;
          end else begin
            cell_next[i] = cells[i-1];
          end
        end else if (i < CAPACITY - 1) begin
          cell_next[i] = cells[(i < CAPACITY - 1) ? i + 1 : i];
        end else begin
          cell_next[i] = cells[i];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (cmd.execute && (do_push || do_pop)) begin
        cells[i] <= cell_next[i];
      end
    end
  end

  // entry count
  always_comb begin
    count_next = count;
    if (do_push) begin
      count_next = count + CNT_W'(1);
    end else if (do_pop) begin
      count_next = count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.execute) begin
      count <= count_next;
    end
  end

  // response register
  always_ff @(posedge clk) begin
    if (cmd.execute) begin
      result_value <= ((is_pop || is_peek) && !empty) ? cells[0] : '0;
      was_empty    <= (is_pop || is_peek) && empty;
      overflow     <= is_push && full;
      occupancy    <= OCC_W'(count_next);
    end
  end

endmodule

>>> design/smpq_checker.sv
// port-level checks of the sorted max priority queue, bound to the top level
`include "assert_macros.svh"

module smpq_checker import smpq_pkg::*; #(
  parameter int CAPACITY = DEFAULT_CAPACITY
) (
  input logic                      clk,
  input logic                      rst,
  input logic                      req_valid,
  input logic                      req_ready,
  input logic                      rsp_valid,
  input logic                      rsp_ready,
  input logic signed [VALUE_W-1:0] result_value,
  input logic                      was_empty,
  input logic                      overflow,
  input logic [OCC_W-1:0]          occupancy
);

  // one operation in flight: no request taken right after one was taken
  `ASSERT_NEXT(a_one_in_flight, clk, rst, req_valid && req_ready, !req_ready, "request taken back to back")

  // a stalled response keeps its value
  `ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready, rsp_valid && $stable(result_value), "stalled response changed")

  // empty and overflow flags exclude each other
  `ASSERT_IMPLIES(a_flags_excl, clk, rst, rsp_valid, !(was_empty && overflow), "empty and overflow both set")

  // an empty pop or peek returns zero
  `ASSERT_IMPLIES(a_empty_zero, clk, rst, rsp_valid && was_empty, result_value == '0, "empty result not zero")

  // a dropped push leaves the queue full
  `ASSERT_IMPLIES(a_ovf_full, clk, rst, rsp_valid && overflow, occupancy == OCC_W'(CAPACITY), "overflow below capacity")

endmodule

bind sorted_max_priority_queue smpq_checker #(
  .CAPACITY (CAPACITY)
) u_smpq_checker (
  .clk          (clk),
  .rst          (rst),
  .req_valid    (req.valid),
  .req_ready    (req.ready),
  .rsp_valid    (rsp.valid),
  .rsp_ready    (rsp.ready),
  .result_value (rsp.result_value),
  .was_empty    (rsp.was_empty),
  .overflow     (rsp.overflow),
  .occupancy    (rsp.occupancy)
);
